@@ hdl/kmp_pkg.sv @@
// Shared constants, register codes and pattern byte select for the KMP matcher.
`default_nettype none

package kmp_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;
   localparam int PATTERN_BITS   = 128;
   localparam int LENGTH_BITS    = 5;
   localparam int START_BITS     = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 2'd2;

   // Select pattern byte k; byte 0 sits in bits 7:0.
   function automatic logic [7:0] pat_byte(input logic [PATTERN_BITS-1:0] pat,
                                           input logic [3:0] k);
      pat_byte = pat[{k, 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

@@ hdl/kmp_table.sv @@
// Pattern registers, effective length and failure table storage for the KMP matcher.
`default_nettype none

module kmp_table #(
   parameter int MAX_PATTERN = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // register write beat
   input  wire logic                                  csr_wr,
   input  wire logic [kmp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [kmp_pkg::CSR_DATA_BITS-1:0]     csr_data,
   // failure table write port
   input  wire logic                                  tbl_wr,
   input  wire logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] tbl_wr_idx,
   input  wire logic [$clog2(MAX_PATTERN+1)-1:0]      tbl_wr_data,
   // failure table read port
   input  wire logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] tbl_rd_idx,
   output logic      [$clog2(MAX_PATTERN+1)-1:0]      tbl_rd_data,
   // pattern view
   output logic      [kmp_pkg::PATTERN_BITS-1:0]      pattern,
   output logic      [$clog2(MAX_PATTERN+1)-1:0]      eff_len
);

   localparam int LenW = $clog2(MAX_PATTERN + 1);

   logic [kmp_pkg::CSR_DATA_BITS-1:0] pat_low_ff;
   logic [kmp_pkg::CSR_DATA_BITS-1:0] pat_high_ff;
   logic [kmp_pkg::LENGTH_BITS-1:0]   length_ff;
   logic [LenW-1:0]                   fail_ff [0:MAX_PATTERN-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         length_ff   <= kmp_pkg::LENGTH_BITS'(1);
      end else if (csr_wr) begin
         case (csr_index)
            kmp_pkg::CSR_PATTERN_LOW:    pat_low_ff  <= csr_data;
            kmp_pkg::CSR_PATTERN_HIGH:   pat_high_ff <= csr_data;
            kmp_pkg::CSR_PATTERN_LENGTH: length_ff   <= csr_data[kmp_pkg::LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Entry 0 is never written; it always reads as zero.
   always_ff @(posedge clock) begin
      if (tbl_wr) begin
         fail_ff[tbl_wr_idx] <= tbl_wr_data;
      end
   end

   assign tbl_rd_data = (tbl_rd_idx == '0) ? '0 : fail_ff[tbl_rd_idx];
   assign pattern     = {pat_high_ff, pat_low_ff};

   // Clamp length: zero acts as one, oversize acts as the maximum.
   always_comb begin
      if (length_ff == '0) begin
         eff_len = LenW'(1);
      end else if (length_ff > kmp_pkg::LENGTH_BITS'(MAX_PATTERN)) begin
         eff_len = LenW'(MAX_PATTERN);
      end else begin
         eff_len = LenW'(length_ff);
      end
   end

endmodule

`default_nettype wire

@@ hdl/kmp_stream_matcher.sv @@
// Top level of the KMP stream matcher: sequencer, shared byte comparator and result register.
// Each accepted byte goes through ST_MATCH (compare, then failure-table fallbacks) and ST_RESULT
//   (load of the result register); one byte comparator is shared by every step.
// req_stall stays high until the result is loaded, so a new byte is taken only once the last is done.
// After reset, or any pattern register write, the failure table is rebuilt
//   with req_stall high; reset leaves pattern 0, length 1.
// Reset is synchronous, active high: position, match length and result valid clear.
`default_nettype none

module kmp_stream_matcher #(
   parameter int MAX_PATTERN   = 16,
   parameter int POSITION_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // text byte channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [7:0]                           req_text_byte,
   input  wire logic                                 req_start_of_text,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_match_found,
   output logic      [kmp_pkg::START_BITS-1:0]       rsp_match_start,
   // configuration write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [kmp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [kmp_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int LenW = $clog2(MAX_PATTERN + 1);
   localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   typedef enum logic [1:0] {
      ST_BUILD,   // walk the pattern, fill the failure table
      ST_IDLE,    // wait for a text byte
      ST_MATCH,   // compare and fall back, one step a cycle
      ST_RESULT   // hand the result to the output register
   } state_type;

   state_type                   state_ff;
   logic [LenW-1:0]             i_ff;      // builder: pattern index
   logic [LenW-1:0]             k_ff;      // builder: border length
   logic [LenW-1:0]             m_ff;      // matched length
   logic [POSITION_BITS-1:0]    pos_ff;
   logic [7:0]                  char_ff;
   logic                        found_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_found_ff;
   logic [kmp_pkg::START_BITS-1:0] rsp_start_ff;

   logic [kmp_pkg::PATTERN_BITS-1:0] pattern;
   logic [LenW-1:0]             eff_len;
   logic                        cfg_wr;
   logic                        tbl_wr;
   logic [IdxW-1:0]             tbl_wr_idx;
   logic [LenW-1:0]             tbl_wr_data;
   logic [IdxW-1:0]             tbl_rd_idx;
   logic [LenW-1:0]             tbl_rd_data;
   logic [7:0]                  cmp_a;
   logic [7:0]                  cmp_b;
   logic                        cmp_eq;
   logic                        out_free;
   logic [LenW-1:0]             m_base;
   logic [POSITION_BITS-1:0]    start_full;
   logic [kmp_pkg::START_BITS-1:0] start_out;

   // Any write to a known register restarts the table build.
   assign cfg_wr = csr_valid && csr_ready &&
                   (csr_index == kmp_pkg::CSR_PATTERN_LOW ||
                    csr_index == kmp_pkg::CSR_PATTERN_HIGH ||
                    csr_index == kmp_pkg::CSR_PATTERN_LENGTH);

   kmp_table #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .csr_wr      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .tbl_wr      (tbl_wr),
      .tbl_wr_idx  (tbl_wr_idx),
      .tbl_wr_data (tbl_wr_data),
      .tbl_rd_idx  (tbl_rd_idx),
      .tbl_rd_data (tbl_rd_data),
      .pattern     (pattern),
      .eff_len     (eff_len)
   );

   // Shared comparator: the builder compares pattern[i] to pattern[k],
   // the matcher compares pattern[m] to the held text byte.
   always_comb begin
      if (state_ff == ST_BUILD) begin
         cmp_a = kmp_pkg::pat_byte(pattern, 4'(i_ff));
         cmp_b = kmp_pkg::pat_byte(pattern, 4'(k_ff));
      end else begin
         cmp_a = kmp_pkg::pat_byte(pattern, 4'(m_ff));
         cmp_b = char_ff;
      end
   end
   assign cmp_eq = (cmp_a == cmp_b);

   // Single failure-table read port, address chosen by the phase.
   always_comb begin
      case (state_ff)
         ST_BUILD:  tbl_rd_idx = IdxW'(k_ff - LenW'(1));
         ST_MATCH:  tbl_rd_idx = IdxW'(m_ff - LenW'(1));
         ST_RESULT: tbl_rd_idx = IdxW'(eff_len - LenW'(1));
         default:   tbl_rd_idx = '0;
      endcase
   end

   // Fill entry i on a hit (k + 1) or when no border remains (zero).
   assign tbl_wr      = (state_ff == ST_BUILD) && (i_ff < eff_len) &&
                        (cmp_eq || (k_ff == '0));
   assign tbl_wr_idx  = IdxW'(i_ff);
   assign tbl_wr_data = cmp_eq ? LenW'(k_ff + LenW'(1)) : '0;

   assign m_base     = req_start_of_text ? '0 : m_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign start_full = pos_ff - POSITION_BITS'(eff_len) + POSITION_BITS'(1);

   generate
      if (POSITION_BITS >= kmp_pkg::START_BITS) begin : g_start_trunc
         assign start_out = start_full[kmp_pkg::START_BITS-1:0];
      end else begin : g_start_ext
         assign start_out = {{(kmp_pkg::START_BITS-POSITION_BITS){1'b0}}, start_full};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BUILD;
         i_ff         <= LenW'(1);
         k_ff         <= '0;
         m_ff         <= '0;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once the consumer takes it, unless a new one loads now.
         if (rsp_valid_ff && !rsp_stall && (cfg_wr || state_ff != ST_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cfg_wr) begin
            // A pattern write rebuilds the table and clears the match length.
            state_ff <= ST_BUILD;
            i_ff     <= LenW'(1);
            k_ff     <= '0;
            m_ff     <= '0;
         end else begin
            case (state_ff)
               ST_BUILD: begin
                  if (i_ff >= eff_len) begin
                     state_ff <= ST_IDLE;
                  end else if (cmp_eq) begin
                     k_ff <= LenW'(k_ff + LenW'(1));
                     i_ff <= LenW'(i_ff + LenW'(1));
                  end else if (k_ff != '0) begin
                     k_ff <= tbl_rd_data;
                  end else begin
                     i_ff <= LenW'(i_ff + LenW'(1));
                  end
               end
               ST_IDLE: begin
                  if (req_valid) begin
                     char_ff <= req_text_byte;
                     if (req_start_of_text) begin
                        pos_ff <= '0;
                     end
                     m_ff     <= (m_base >= eff_len) ? '0 : m_base;
                     state_ff <= ST_MATCH;
                  end
               end
               ST_MATCH: begin
                  if (cmp_eq) begin
                     m_ff     <= LenW'(m_ff + LenW'(1));
                     found_ff <= (LenW'(m_ff + LenW'(1)) == eff_len);
                     state_ff <= ST_RESULT;
                  end else if (m_ff != '0) begin
                     m_ff <= tbl_rd_data;
                  end else begin
                     found_ff <= 1'b0;
                     state_ff <= ST_RESULT;
                  end
               end
               ST_RESULT: begin
                  // Hold here until the output register is free.
                  if (out_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_found_ff <= found_ff;
                     rsp_start_ff <= found_ff ? start_out : '0;
                     if (found_ff) begin
                        m_ff <= tbl_rd_data;
                     end
                     pos_ff   <= pos_ff + POSITION_BITS'(1);
                     state_ff <= ST_IDLE;
                  end
               end
               default: begin
                  state_ff <= ST_IDLE;
               end
            endcase
         end
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_found = rsp_found_ff;
   assign rsp_match_start = rsp_start_ff;

   // Matched length stays below the pattern length between bytes.
   a_m_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (m_ff < eff_len))
      else $error("matched length not below pattern length while idle");

   // While matching, fallbacks never reach the full pattern length.
   a_match_m_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATCH && !cfg_wr) |-> (m_ff < eff_len))
      else $error("matched length out of range during compare");

   // The builder's border length stays below its index.
   a_build_k_lt_i: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUILD && i_ff < eff_len) |-> (k_ff < i_ff))
      else $error("failure builder border not below index");

   // A pattern register write always restarts the table build.
   a_cfg_rebuild: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (state_ff == ST_BUILD && m_ff == '0))
      else $error("pattern write did not restart table build");

   // A result is only loaded out of the result phase.
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |->
         ($past(state_ff) == ST_RESULT))
      else $error("result loaded outside result phase");

endmodule

`default_nettype wire

@@ tb/tb_kmp_stream_matcher.sv @@
// Self-checking testbench for the KMP stream matcher: directed and random text against a predictor.
`default_nettype none

module tb_kmp_stream_matcher;

   localparam int MAX_PATTERN     = 16;
   localparam int POSITION_BITS   = 32;
   localparam int RANDOM_BYTES    = 1300;
   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 64;
   localparam int IDLE_PERCENT    = 9;

   // Index past the last register; the block must drop writes to it.
   localparam logic [kmp_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic                           found;
      logic [kmp_pkg::START_BITS-1:0] start;
   } match_beat_t;

   // Predictor and expected-beat store. Mirrors the pattern registers, the
   // failure table and the running search state of the matcher.
   class kmp_match_scoreboard;
      logic [kmp_pkg::PATTERN_BITS-1:0] pattern;
      logic [kmp_pkg::LENGTH_BITS-1:0]  length_reg;
      logic [kmp_pkg::LENGTH_BITS-1:0]  fail_tab [MAX_PATTERN];
      logic [kmp_pkg::LENGTH_BITS-1:0]  matched;
      logic [POSITION_BITS-1:0]         position;
      match_beat_t                      expected_matches [$];
      int                               errors;

      function new();
         pattern    = '0;
         length_reg = 5'd1;
         position   = '0;
         errors     = 0;
         rebuild_failure();
      endfunction

      function int eff_len();
         if (length_reg == 0)
            return 1;
         if (length_reg > MAX_PATTERN)
            return MAX_PATTERN;
         return int'(length_reg);
      endfunction

      function logic [7:0] byte_at(int k);
         return pattern[(k & 15) * 8 +: 8];
      endfunction

      // Longest proper prefix that is also a suffix, per pattern prefix.
      function void rebuild_failure();
         int n;
         int i;
         int k;
         n = eff_len();
         i = 1;
         k = 0;
         foreach (fail_tab[x])
            fail_tab[x] = '0;
         while (i < n) begin
            if (byte_at(i) == byte_at(k)) begin
               k++;
               fail_tab[i] = 5'(k);
               i++;
            end else if (k != 0) begin
               k = int'(fail_tab[k - 1]);
            end else begin
               fail_tab[i] = '0;
               i++;
            end
         end
         matched = '0;
      endfunction

      function void write_register(logic [kmp_pkg::CSR_INDEX_BITS-1:0] idx,
                                   logic [kmp_pkg::CSR_DATA_BITS-1:0] data);
         case (idx)
            kmp_pkg::CSR_PATTERN_LOW:    pattern[63:0]   = data;
            kmp_pkg::CSR_PATTERN_HIGH:   pattern[127:64] = data;
            kmp_pkg::CSR_PATTERN_LENGTH: length_reg      = data[4:0];
            default:                     return;
         endcase
         rebuild_failure();
      endfunction

      // Step the search by one accepted text byte and queue the beat it must produce.
      function void note_text_byte(logic [7:0] text_byte, logic start_of_text);
         int          n;
         match_beat_t beat;
         n    = eff_len();
         beat = '0;
         if (start_of_text) begin
            position = '0;
            matched  = '0;
         end
         if (matched >= n)
            matched = '0;
         while (matched > 0 && byte_at(int'(matched)) != text_byte)
            matched = fail_tab[(int'(matched) - 1) & (MAX_PATTERN - 1)];
         if (byte_at(int'(matched)) == text_byte)
            matched++;
         if (matched == n) begin
            beat.found = 1'b1;
            beat.start = position - POSITION_BITS'(n) + 1'b1;
            matched    = fail_tab[n - 1];
         end
         position++;
         expected_matches.push_back(beat);
      endfunction

      function void check_result(logic found, logic [kmp_pkg::START_BITS-1:0] start);
         match_beat_t want;
         if (expected_matches.size() == 0) begin
            $display("%0t: result beat with none expected: found %0d start %0d",
                     $time, found, start);
            errors++;
            return;
         end
         want = expected_matches.pop_front();
         if (found !== want.found) begin
            $display("%0t: match_found expected %0d actual %0d", $time, want.found, found);
            errors++;
         end
         if (start !== want.start) begin
            $display("%0t: match_start expected %0d actual %0d", $time, want.start, start);
            errors++;
         end
      endfunction

      function int pending();
         return expected_matches.size();
      endfunction
   endclass

   logic                                clock;
   logic                                reset             = 1'b1;
   logic                                req_valid         = 1'b0;
   logic                                req_stall;
   logic [7:0]                          req_text_byte     = '0;
   logic                                req_start_of_text = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall         = 1'b0;
   logic                                rsp_match_found;
   logic [kmp_pkg::START_BITS-1:0]      rsp_match_start;
   logic                                csr_valid         = 1'b0;
   logic                                csr_ready;
   logic [kmp_pkg::CSR_INDEX_BITS-1:0]  csr_index         = '0;
   logic [kmp_pkg::CSR_DATA_BITS-1:0]   csr_data          = '0;

   kmp_match_scoreboard                 sb = new();

   // Pattern and length as last written; text generation draws on these so it
   // never races the scoreboard update at the write edge.
   logic [kmp_pkg::PATTERN_BITS-1:0]    live_pattern = '0;
   int                                  live_length  = 1;

   bit                                  no_idle = 1'b0;
   int                                  bytes_sent = 0;
   int                                  quiet_cycles = 0;

   kmp_stream_matcher #(
      .MAX_PATTERN   (MAX_PATTERN),
      .POSITION_BITS (POSITION_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .req_start_of_text (req_start_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_match_found   (rsp_match_found),
      .rsp_match_start   (rsp_match_start),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the result side at random, except during the no-idle stretch.
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Monitor: sample all three channels at the edge. Register writes and text
   // beats feed the predictor; result beats are checked in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_register(csr_index, csr_data);
         if (req_valid && !req_stall)
            sb.note_text_byte(req_text_byte, req_start_of_text);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_match_found, rsp_match_start);
      end
   end

   // Watchdog: count edges with no beat on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offer one text beat and hold it until accepted. Valid stays high on
   // return so a back-to-back beat just swaps the payload.
   task automatic send_byte(input logic [7:0] text_byte, input logic start_of_text);
      if (!no_idle) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_text_byte     <= text_byte;
      req_start_of_text <= start_of_text;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bytes_sent++;
   endtask

   // Drop valid and hold until every expected beat has come back. Poll on
   // the falling edge so the check never races the monitor.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (sb.pending() != 0);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [kmp_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [kmp_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // Write the selected registers (low, high, length by bit of which), then
   // optionally poke the unused index; lower valid only after the last write.
   task automatic load_pattern(input logic [kmp_pkg::PATTERN_BITS-1:0] pat,
                               input logic [kmp_pkg::CSR_DATA_BITS-1:0] length_word,
                               input logic [2:0] which, input bit poke_unused);
      if (which[0]) begin
         write_csr(kmp_pkg::CSR_PATTERN_LOW, pat[63:0]);
         live_pattern[63:0] = pat[63:0];
      end
      if (which[1]) begin
         write_csr(kmp_pkg::CSR_PATTERN_HIGH, pat[127:64]);
         live_pattern[127:64] = pat[127:64];
      end
      if (which[2]) begin
         write_csr(kmp_pkg::CSR_PATTERN_LENGTH, length_word);
         live_length = int'(length_word[4:0]);
         if (live_length == 0)
            live_length = 1;
         if (live_length > MAX_PATTERN)
            live_length = MAX_PATTERN;
      end
      if (poke_unused)
         write_csr(CSR_UNUSED, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   function automatic logic pick_start(int offset);
      if (offset == 0)
         return $urandom_range(99) < 60;
      return $urandom_range(99) < 2;
   endfunction

   initial begin : stimulus
      int                               phase;
      int                               k;
      int                               j;
      int                               frag;
      int                               phase_len;
      int                               nsym;
      int                               r;
      logic [7:0]                       syms [3];
      logic [kmp_pkg::PATTERN_BITS-1:0] pat;
      logic [4:0]                       len;
      logic [kmp_pkg::CSR_DATA_BITS-1:0] length_word;
      logic [2:0]                       which;
      bit                               paused;
      logic [7:0]                       text_byte;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset pattern is a single zero byte: every zero byte matches.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);

      // Full-length all-ones pattern; a run of 17 ones matches twice, the two overlapping.
      wait_drained();
      load_pattern({128{1'b1}}, 64'd16, 3'b111, 1'b0);
      send_byte(8'hFF, 1'b1);
      repeat (16)
         send_byte(8'hFF, 1'b0);

      // Length zero acts as one; rewrite mid-text keeps the position.
      wait_drained();
      load_pattern(live_pattern, 64'd0, 3'b100, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);

      // Random phases: small-alphabet patterns and text built mostly from
      // pattern prefixes so the fallback path gets exercised hard.
      phase = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         wait_drained();
         no_idle = (phase == 6);

         nsym = $urandom_range(1, 3);
         foreach (syms[x])
            syms[x] = 8'($urandom);
         pat = {$urandom, $urandom, $urandom, $urandom};
         if ($urandom_range(99) < 90) begin
            for (j = 0; j < MAX_PATTERN; j++)
               pat[j * 8 +: 8] = syms[$urandom_range(nsym - 1)];
         end

         r = $urandom_range(99);
         if (r < 8)
            len = 5'd0;
         else if (r < 16)
            len = 5'($urandom_range(17, 31));
         else if (r < 26)
            len = 5'd16;
         else if (r < 34)
            len = 5'd1;
         else
            len = 5'($urandom_range(2, 15));
         length_word = {59'($urandom_range(1) ? {$urandom, $urandom} : 64'd0), len};

         which = (phase == 0) ? 3'b111 : 3'($urandom);
         load_pattern(pat, length_word, which, $urandom_range(99) < 8);

         phase_len = no_idle ? 200 : $urandom_range(20, 120);
         paused = 1'b0;
         k = 0;
         while (k < phase_len) begin
            // Hold the sender once until the pipeline is empty.
            if (phase == 3 && !paused && k >= phase_len / 2) begin
               wait_drained();
               paused = 1'b1;
            end
            if ($urandom_range(99) < 55) begin
               frag = ($urandom_range(99) < 60) ? live_length : $urandom_range(1, live_length);
               for (j = 0; j < frag && k < phase_len; j++) begin
                  send_byte(live_pattern[j * 8 +: 8], pick_start(k));
                  k++;
               end
            end else begin
               if ($urandom_range(99) < 80)
                  text_byte = syms[$urandom_range(nsym - 1)];
               else
                  text_byte = 8'($urandom);
               send_byte(text_byte, pick_start(k));
               k++;
            end
         end
         phase++;
      end

      // Drain, then let the block run on a while to catch stray beats.
      wait_drained();
      no_idle = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         $display("%0t: %0d expected beats never arrived", $time, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
